/* hdl/gtp_pkg.sv */
//------------------------------------------------------------------------------
// gtp_pkg
// Shared types, constants and tables for the go-to-point drive controller.
//------------------------------------------------------------------------------
`default_nettype none
package gtp_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TABLE_LEN        = 30;
	localparam int CFG_IDX_W        = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_BASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_RAD   = 3'd4;

	localparam logic [30:0] TOL_RST       = 31'd3277;
	localparam logic [31:0] GAIN_RST      = 32'd65536;
	localparam logic [31:0] SPEED_RST     = 32'd13107;
	localparam logic [30:0] HALF_BASE_RST = 31'd6554;
	localparam logic [30:0] INV_RAD_RST   = 31'd1310720;

	localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

	typedef enum logic [1:0] {
		KIND_DEST  = 2'd0,
		KIND_DRIVE = 2'd1,
		KIND_STOP  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [30:0]        tolerance;
		logic signed [31:0] heading_gain;
		logic signed [31:0] travel_speed;
		logic [30:0]        half_wheel_base;
		logic [30:0]        inverse_wheel_radius;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_DEST_DONE,
		ST_DIST_X,
		ST_DIST_Y,
		ST_OMEGA,
		ST_TURN,
		ST_LEFT,
		ST_RIGHT,
		ST_OUT
	} state_t;

	// multiplier request from the sequencer
	typedef struct packed {
		logic               start;
		logic signed [63:0] a;
		logic [31:0]        b;
	} mul_req_t;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 34'sh3243F6A8;
			5'd1:  atan_q30 = 34'sh1DAC6705;
			5'd2:  atan_q30 = 34'sh0FADBAFC;
			5'd3:  atan_q30 = 34'sh07F56EA6;
			5'd4:  atan_q30 = 34'sh03FEAB76;
			5'd5:  atan_q30 = 34'sh01FFD55B;
			5'd6:  atan_q30 = 34'sh00FFFAAA;
			5'd7:  atan_q30 = 34'sh007FFF55;
			5'd8:  atan_q30 = 34'sh003FFFEA;
			5'd9:  atan_q30 = 34'sh001FFFFD;
			5'd10: atan_q30 = 34'sh000FFFFF;
			5'd11: atan_q30 = 34'sh0007FFFF;
			5'd12: atan_q30 = 34'sh0003FFFF;
			5'd13: atan_q30 = 34'sh0001FFFF;
			5'd14: atan_q30 = 34'sh0000FFFF;
			5'd15: atan_q30 = 34'sh00007FFF;
			5'd16: atan_q30 = 34'sh00003FFF;
			5'd17: atan_q30 = 34'sh00001FFF;
			5'd18: atan_q30 = 34'sh00000FFF;
			5'd19: atan_q30 = 34'sh000007FF;
			5'd20: atan_q30 = 34'sh000003FF;
			5'd21: atan_q30 = 34'sh000001FF;
			5'd22: atan_q30 = 34'sh000000FF;
			5'd23: atan_q30 = 34'sh0000007F;
			5'd24: atan_q30 = 34'sh0000003F;
			5'd25: atan_q30 = 34'sh0000001F;
			5'd26: atan_q30 = 34'sh0000000F;
			5'd27: atan_q30 = 34'sh00000008;
			5'd28: atan_q30 = 34'sh00000004;
			5'd29: atan_q30 = 34'sh00000002;
			default: atan_q30 = 34'sh0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			sat32 = 32'sh7FFFFFFF;
		else if (v < -66'sd2147483648)
			sat32 = 32'sh80000000;
		else
			sat32 = v[31:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/gtp_stream_if.sv */
//------------------------------------------------------------------------------
// gtp_stream_if
// Valid/ready channel carrying one payload struct or vector.
//------------------------------------------------------------------------------
`default_nettype none
interface gtp_stream_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/gtp_serial_mul.sv */
//------------------------------------------------------------------------------
// gtp_serial_mul
// Signed by unsigned shift-add multiplier, one multiplier bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module gtp_serial_mul
	import gtp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mul_req_t           req,
	output logic                    done,
	output logic signed [95:0]      product
);
	logic signed [95:0] acc_q;
	logic signed [95:0] mcand_q;
	logic [31:0]        mplier_q;
	logic [5:0]         cnt_q;
	logic               busy_q;

	// shift-add, multiplier shifts right one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= 96'(req.a);
			mplier_q <= req.b;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign product = acc_q;

`ifndef ASSERT_OFF
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("multiplier done held");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q)
		else $error("multiplier busy at done");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && cnt_q == 6'd31) |=> done)
		else $error("multiplier missed done");
`endif
endmodule
`default_nettype wire

/* hdl/gtp_cordic.sv */
//------------------------------------------------------------------------------
// gtp_cordic
// Vectoring CORDIC for atan2, one micro-rotation per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module gtp_cordic
	import gtp_pkg::*;
#(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] x_in,
	input  wire logic signed [31:0] y_in,
	output logic                    done,
	output logic signed [33:0]      angle
);
	localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int SH    = 30 - FRAC_BITS;

	logic signed [63:0] xs_q, ys_q;
	logic signed [35:0] z_q;
	logic [4:0]         i_q;
	logic               busy_q;
	logic               zero_q;
	logic signed [32:0] xn, yn;
	logic signed [35:0] zr;

	assign xn = 33'(x_in);
	assign yn = 33'(y_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(NSTEP - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// quadrant fold on start, then rotate toward the x axis
	always_ff @(posedge clk) begin
		if (start) begin
			// origin gives angle zero
			zero_q <= (x_in == 32'sd0) && (y_in == 32'sd0);
			if (x_in < 0) begin
				xs_q <= (64'(-xn)) <<< 28;
				ys_q <= (64'(-yn)) <<< 28;
				z_q  <= (-yn <= 0) ? 36'(PI_Q30) : -36'(PI_Q30);
			end else begin
				xs_q <= 64'(xn) <<< 28;
				ys_q <= 64'(yn) <<< 28;
				z_q  <= '0;
			end
		end else if (busy_q) begin
			if (ys_q >= 0) begin
				xs_q <= xs_q + (ys_q >>> i_q);
				ys_q <= ys_q - (xs_q >>> i_q);
				z_q  <= z_q + 36'(atan_q30(i_q));
			end else begin
				xs_q <= xs_q - (ys_q >>> i_q);
				ys_q <= ys_q + (xs_q >>> i_q);
				z_q  <= z_q - 36'(atan_q30(i_q));
			end
		end
	end

	assign zr    = (z_q + (36'sd1 <<< (SH - 1))) >>> SH;
	assign angle = zero_q ? 34'sd0 : zr[33:0];

`ifndef ASSERT_OFF
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("cordic done held");
	a_idle_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q)
		else $error("cordic busy at done");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> i_q < 5'(NSTEP))
		else $error("cordic step out of range");
`endif
endmodule
`default_nettype wire

/* hdl/go_to_point_drive_controller.sv */
// a destination runs the CORDIC; a tick runs the multiplier for dist x, dist y, omega, turn, left, right
// throughput: one item at a time; the next is taken once the result is handed off
// the processing time is set by the bit-serial shift-add multiplier (one bit a cycle)
// and the CORDIC unit (one micro-rotation a cycle)
// asynchronous active-low reset restores register defaults and clears target, last heading, route and valid flags
//------------------------------------------------------------------------------
// go_to_point_drive_controller
// Go-to-point proportional heading controller for a differential drive.
//------------------------------------------------------------------------------
`default_nettype none
module go_to_point_drive_controller
	import gtp_pkg::*;
#(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	gtp_stream_if.sink                in_ch,
	gtp_stream_if.source              out_ch
);
	localparam int FB         = FRAC_BITS;
	localparam int WRAP_STEPS = 32 - FB;

	cfg_t   cfg_q;
	state_t state_q, state_d;

	logic signed [31:0] dx_q, dy_q, px_q, py_q, ph_q;
	logic signed [31:0] target_x_q, target_y_q, target_heading_q, last_heading_q;
	logic               in_route_q;
	logic [64:0]        dist_q;
	logic signed [31:0] vr_q, left_q, right_q;
	logic signed [33:0] err_q;
	logic [1:0]         kind_q;
	logic               rst_req_q;
	logic               out_valid_q;
	logic               in_take, out_take;

	logic               cor_start, cor_done;
	logic signed [33:0] cor_angle;
	mul_req_t           mreq;
	logic               mul_done;
	logic signed [95:0] mprod;

	// payload unpack: {opcode, dest_x, dest_y, pose_x, pose_y, pose_heading}
	assign in_take  = in_ch.valid && in_ch.ready;
	assign out_take = out_ch.valid && out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance            <= TOL_RST;
			cfg_q.heading_gain         <= GAIN_RST;
			cfg_q.travel_speed         <= SPEED_RST;
			cfg_q.half_wheel_base      <= HALF_BASE_RST;
			cfg_q.inverse_wheel_radius <= INV_RAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOLERANCE: cfg_q.tolerance            <= cfg_data[30:0];
				REG_GAIN:      cfg_q.heading_gain         <= cfg_data;
				REG_SPEED:     cfg_q.travel_speed         <= cfg_data;
				REG_HALF_BASE: cfg_q.half_wheel_base      <= cfg_data[30:0];
				REG_INV_RAD:   cfg_q.inverse_wheel_radius <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// the cordic loads its operands at the accepting edge
	gtp_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start),
		.x_in(in_ch.data[159:128]), .y_in(in_ch.data[127:96]),
		.done(cor_done), .angle(cor_angle)
	);

	gtp_serial_mul u_mul (
		.clk(clk), .arst_n(arst_n), .req(mreq), .done(mul_done), .product(mprod)
	);

	// product rounded back to FB fraction bits
	logic signed [95:0] prod_r;
	assign prod_r = (mprod + (96'sd1 <<< (FB - 1))) >>> FB;

	// wrap of target heading minus pose heading, period 2*pi
	logic signed [33:0] pq;
	assign pq = 34'((PI_Q30 + (34'sd1 <<< (29 - FB))) >>> (30 - FB));
	logic signed [35:0] pq36, pp, wrap_rem_q, wrap_div_q, e2;
	logic [4:0]         wrap_cnt_q;
	logic signed [31:0] ph_in;
	assign pq36  = 36'(pq);
	assign pp    = pq36 <<< 1;
	assign ph_in = in_ch.data[31:0];

	// offset by a multiple of 2*pi to make it positive, then one
	// compare and subtract per cycle over WRAP_STEPS halvings of the divisor, done well before use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_rem_q <= '0;
			wrap_div_q <= '0;
			wrap_cnt_q <= '0;
		end else if (in_take) begin
			wrap_rem_q <= 36'(target_heading_q) - 36'(ph_in) + pq36 + (pp <<< (30 - FB));
			wrap_div_q <= pp <<< (31 - FB);
			wrap_cnt_q <= 5'(WRAP_STEPS);
		end else if (wrap_cnt_q != 5'd0) begin
			if (wrap_rem_q >= wrap_div_q)
				wrap_rem_q <= wrap_rem_q - wrap_div_q;
			wrap_div_q <= wrap_div_q >>> 1;
			wrap_cnt_q <= wrap_cnt_q - 5'd1;
		end
	end
	assign e2 = wrap_rem_q - pq36;

	// distance terms, pose x taken from the bus on the accepting edge
	logic signed [31:0] px_src;
	assign px_src = (state_q == ST_IDLE) ? in_ch.data[95:64] : px_q;
	logic signed [32:0] ddx, ddy;
	assign ddx = 33'(target_x_q) - 33'(px_src);
	assign ddy = 33'(target_y_q) - 33'(py_q);
	logic [31:0] adx, ady;
	assign adx = ddx[32] ? 32'(-ddx) : ddx[31:0];
	assign ady = ddy[32] ? 32'(-ddy) : ddy[31:0];
	logic [61:0] tol2;
	assign tol2 = 62'(cfg_q.tolerance) * 62'(cfg_q.tolerance);

	// turn and linear speeds
	logic signed [65:0] vrs, vls;
	assign vrs = 66'(cfg_q.travel_speed) + 66'(prod_r);
	assign vls = 66'(cfg_q.travel_speed) - 66'(prod_r);

	// heading gain is signed: unsigned shift-add takes its bits as unsigned,
	// so correct by subtracting error<<32 when gain is negative
	logic signed [95:0] omega_prod;
	assign omega_prod = mprod - (cfg_q.heading_gain[31] ? (96'(err_q) <<< 32) : 96'sd0);
	logic signed [95:0] omega_r;
	assign omega_r = (omega_prod + (96'sd1 <<< (FB - 1))) >>> FB;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (in_take) state_d = in_ch.data[160] ? ST_DIST_X : ST_CORDIC;
			ST_CORDIC:    if (cor_done) state_d = ST_DEST_DONE;
			ST_DEST_DONE: state_d = ST_OUT;
			ST_DIST_X:    if (mul_done) state_d = ST_DIST_Y;
			ST_DIST_Y:    if (mul_done) state_d = ST_OMEGA;
			ST_OMEGA:     if (mul_done) state_d = ST_TURN;
			ST_TURN:      if (mul_done) state_d = ST_LEFT;
			ST_LEFT:      if (mul_done) state_d = ST_RIGHT;
			ST_RIGHT:     if (mul_done) state_d = ST_OUT;
			ST_OUT:       state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// unit starts
	always_comb begin
		cor_start = (state_q == ST_IDLE) && in_take && !in_ch.data[160];
		mreq = '0;
		case (state_d)
			ST_DIST_X: begin
				mreq.start = (state_q == ST_IDLE) && in_take;
				mreq.a = 64'(adx);
				mreq.b = adx;
			end
			ST_DIST_Y: begin
				mreq.start = (state_q == ST_DIST_X) && mul_done;
				mreq.a = 64'(ady);
				mreq.b = ady;
			end
			ST_OMEGA: begin
				mreq.start = (state_q == ST_DIST_Y) && mul_done;
				mreq.a = 64'(e2);
				mreq.b = cfg_q.heading_gain;
			end
			ST_TURN: begin
				mreq.start = (state_q == ST_OMEGA) && mul_done;
				mreq.a = 64'(sat32(omega_r[65:0]));
				mreq.b = 32'(cfg_q.half_wheel_base);
			end
			ST_LEFT: begin
				mreq.start = (state_q == ST_TURN) && mul_done;
				mreq.a = 64'(sat32(vls));
				mreq.b = 32'(cfg_q.inverse_wheel_radius);
			end
			ST_RIGHT: begin
				mreq.start = (state_q == ST_LEFT) && mul_done;
				mreq.a = 64'(vr_q);
				mreq.b = 32'(cfg_q.inverse_wheel_radius);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// datapath and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q       <= '0;
			target_y_q       <= '0;
			target_heading_q <= '0;
			last_heading_q   <= '0;
			in_route_q       <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (out_take)
				out_valid_q <= 1'b0;
			if (state_q == ST_OUT)
				out_valid_q <= 1'b1;
			if (state_q == ST_DEST_DONE) begin
				target_x_q       <= sat32(dx_q[31] ? -66'(dx_q) : 66'(dx_q));
				target_y_q       <= sat32(dy_q[31] ? -66'(dy_q) : 66'(dy_q));
				target_heading_q <= sat32(66'(cor_angle) - 66'(last_heading_q));
				in_route_q       <= 1'b1;
			end
			if (state_q == ST_DIST_Y && mul_done) begin
				last_heading_q <= ph_q;
				if (!((dist_q + 65'(mprod[63:0])) > 65'(tol2)))
					in_route_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			dx_q     <= in_ch.data[159:128];
			dy_q     <= in_ch.data[127:96];
			px_q     <= in_ch.data[95:64];
			py_q     <= in_ch.data[63:32];
			ph_q     <= in_ch.data[31:0];
		end
		case (state_q)
			ST_DEST_DONE: begin
				kind_q    <= KIND_DEST;
				rst_req_q <= 1'b1;
				left_q    <= '0;
				right_q   <= '0;
			end
			ST_DIST_X: if (mul_done) dist_q <= 65'(mprod[63:0]);
			ST_DIST_Y: if (mul_done) begin
				dist_q    <= dist_q + 65'(mprod[63:0]);
				err_q     <= e2[33:0];
				rst_req_q <= 1'b0;
				left_q    <= '0;
				right_q   <= '0;
				kind_q    <= ((dist_q + 65'(mprod[63:0])) > 65'(tol2)) ? KIND_DRIVE : KIND_STOP;
			end
			ST_TURN: if (mul_done) vr_q <= sat32(vrs);
			ST_LEFT:  if (mul_done && kind_q == KIND_DRIVE) left_q <= sat32(prod_r[65:0]);
			ST_RIGHT: if (mul_done && kind_q == KIND_DRIVE) right_q <= sat32(prod_r[65:0]);
			default: ;
		endcase
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = {kind_q, left_q, right_q, in_route_q, rst_req_q};

`ifndef ASSERT_OFF
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> out_valid_q)
		else $error("result dropped");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready)
		else $error("input taken while busy");
	a_dest_route: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEST_DONE) |=> in_route_q)
		else $error("route flag not set");
`endif
endmodule
`default_nettype wire
